@@ rtl/core/simt_divergence_stack_core_macros.svh @@
// assertion macros used by the warp control datapath
`ifndef SIMT_DIVERGENCE_STACK_CORE_MACROS_SVH
`define SIMT_DIVERGENCE_STACK_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define SDS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define SDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sds_pkg.sv @@
// shared constants, opcodes and control structs of the warp control core
package sds_pkg;

    localparam int LANES_DEF       = 32;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int PC_BITS_DEF     = 48;

    localparam int OPCODE_W = 3;
    localparam int TIDX_W   = 5;
    localparam int TCOUNT_W = 6;

    // fall-through distance of one instruction
    localparam int PC_STEP = 4;

    localparam logic [OPCODE_W-1:0] OP_LAUNCH  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_RECORD  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_DIVERGE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SET_PC  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_STOP    = 3'd4;

    typedef struct packed {
        logic accept;
        logic exec;
        logic stack_rd;
        logic scan_issue;
        logic merge;
        logic push_a;
        logic push_b;
        logic pop_load;
        logic out_load;
    } sds_cmd_t;

    typedef struct packed {
        logic is_diverge;
        logic pop_req;
        logic scan_end;
        logic push_any;
        logic push_two;
        logic out_free;
    } sds_status_t;

endpackage

@@ rtl/core/sds_ctrl.sv @@
// sequencing state machine of the warp control core
module sds_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sds_pkg::sds_status_t  status,
    output sds_pkg::sds_cmd_t     cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_EXEC   = 8'b0000_0010,
        ST_SCAN   = 8'b0000_0100,
        ST_MERGE  = 8'b0000_1000,
        ST_PUSH_A = 8'b0001_0000,
        ST_PUSH_B = 8'b0010_0000,
        ST_LOAD   = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec     = 1'b1;
                cmd.stack_rd = 1'b1;
                if (status.is_diverge)
                begin
                    state_next = ST_SCAN;
                end
                else if (status.pop_req)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_MERGE;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                end
            end
            ST_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = status.push_any ? ST_PUSH_A : ST_FINISH;
            end
            ST_PUSH_A:
            begin
                cmd.push_a = 1'b1;
                state_next = status.push_two ? ST_PUSH_B : ST_FINISH;
            end
            ST_PUSH_B:
            begin
                cmd.push_b = 1'b1;
                state_next = ST_FINISH;
            end
            ST_LOAD:
            begin
                cmd.pop_load = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/sds_datapath.sv @@
// warp state, lane pc memory, reconvergence stack and result register
`include "simt_divergence_stack_core_macros.svh"

module sds_datapath
#(
    parameter int LANES       = sds_pkg::LANES_DEF,
    parameter int STACK_DEPTH = sds_pkg::STACK_DEPTH_DEF,
    parameter int PC_BITS     = sds_pkg::PC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sds_pkg::sds_cmd_t             cmd,
    output sds_pkg::sds_status_t          status,
    input  logic [sds_pkg::OPCODE_W-1:0]  opcode,
    input  logic [sds_pkg::TIDX_W-1:0]    thread_index,
    input  logic [PC_BITS-1:0]            address,
    input  logic [LANES-1:0]              lane_mask,
    input  logic [sds_pkg::TCOUNT_W-1:0]  thread_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [PC_BITS-1:0]            next_pc,
    output logic [LANES-1:0]              next_lanes,
    output logic                          warp_done,
    output logic                          stack_overflow
);

    localparam int LIW = $clog2(LANES);
    localparam int SXW = $clog2(LANES + 1);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int GW  = PC_BITS + LANES;

    // latched item
    logic [sds_pkg::OPCODE_W-1:0] op_reg;
    logic [sds_pkg::TIDX_W-1:0]   tidx_reg;
    logic [PC_BITS-1:0]           addr_reg;
    logic [LANES-1:0]             mask_reg;
    logic [sds_pkg::TCOUNT_W-1:0] tcount_reg;

    // warp state
    logic [PC_BITS-1:0] warp_pc_reg,  warp_pc_next;
    logic [LANES-1:0]   active_reg,   active_next;
    logic [LANES-1:0]   stopped_reg,  stopped_next;
    logic [LANES-1:0]   tvalid_reg,   tvalid_next;
    logic [SCW-1:0]     stk_cnt_reg,  stk_cnt_next;
    logic [SXW-1:0]     scan_idx_reg, scan_idx_next;
    logic               done_reg,     done_next;
    logic               ovf_reg,      ovf_next;
    logic               out_valid_reg, out_valid_next;

    // memories
    logic [PC_BITS-1:0] tnpc_mem [LANES];
    logic [PC_BITS-1:0] tnpc_rd_reg;
    logic [GW-1:0]      stk_mem [STACK_DEPTH];
    logic [GW-1:0]      stk_rd_reg;

    // scan pipeline
    logic               proc_en_reg;
    logic               proc_valid_reg;
    logic [LIW-1:0]     proc_lane_reg;
    logic [PC_BITS-1:0] fall_pc_reg,  taken_pc_reg;
    logic [LANES-1:0]   fall_lanes_reg, taken_lanes_reg;

    // merge results
    logic [PC_BITS-1:0] res_pc_reg;
    logic [LANES-1:0]   res_lanes_reg;
    logic [GW-1:0]      push_a_reg, push_b_reg;
    logic               push_two_reg;

    logic [PC_BITS-1:0] next_pc_reg;
    logic [LANES-1:0]   next_lanes_reg;
    logic               warp_done_reg;
    logic               ovf_out_reg;

    logic [LANES-1:0]   launch_en;
    logic               tidx_ok;
    logic [LIW-1:0]     tidx_idx;
    logic [LIW-1:0]     scan_lane;
    logic               all_stopped;
    logic               pc_zero;
    logic               stk_empty;
    logic               stk_full;
    logic [SCW-1:0]     stk_cnt_dec;
    logic [PC_BITS-1:0] target_pc;
    logic [PC_BITS-1:0] lane_pc;
    logic [PC_BITS-1:0] stk_rd_pc;
    logic [LANES-1:0]   stk_rd_lanes;
    logic               push;
    logic [GW-1:0]      push_data;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            launch_en[i] = (32'(tcount_reg) > i);
        end
    end

    assign tidx_ok      = (32'(tidx_reg) < LANES);
    assign tidx_idx     = LIW'(tidx_reg);
    assign scan_lane    = scan_idx_reg[LIW-1:0];
    assign all_stopped  = &stopped_reg;
    assign pc_zero      = (warp_pc_reg == '0);
    assign stk_empty    = (stk_cnt_reg == '0);
    assign stk_full     = (stk_cnt_reg == SCW'(STACK_DEPTH));
    assign stk_cnt_dec  = stk_cnt_reg - SCW'(1);
    assign target_pc    = warp_pc_reg + PC_BITS'(sds_pkg::PC_STEP);
    assign lane_pc      = proc_valid_reg ? tnpc_rd_reg : '0;
    assign stk_rd_pc    = stk_rd_reg[GW-1:LANES];
    assign stk_rd_lanes = stk_rd_reg[LANES-1:0];
    assign push         = cmd.push_a | cmd.push_b;
    assign push_data    = cmd.push_b ? push_b_reg : push_a_reg;

    // merge of fall-through, taken and popped top
    logic [PC_BITS-1:0] top_pc;
    logic [LANES-1:0]   top_lanes;
    logic               f_empty, t_empty, p_empty;
    logic               ft_ok, ftp_ok, fp_ok, tp_ok;
    logic [PC_BITS-1:0] ft_pc, ftp_pc;
    logic [LANES-1:0]   ft_lanes, ftp_lanes, fp_lanes, tp_lanes;
    logic [PC_BITS-1:0] res_pc;
    logic [LANES-1:0]   res_lanes;
    logic [GW-1:0]      push_a_val, push_b_val;
    logic [1:0]         push_n;

    always_comb
    begin
        top_pc    = stk_empty ? '0 : stk_rd_pc;
        top_lanes = stk_empty ? '0 : stk_rd_lanes;
        f_empty   = (fall_lanes_reg == '0);
        t_empty   = (taken_lanes_reg == '0);
        p_empty   = (top_lanes == '0);

        ft_ok    = f_empty || t_empty || (fall_pc_reg == taken_pc_reg);
        ft_pc    = f_empty ? taken_pc_reg : fall_pc_reg;
        ft_lanes = f_empty ? taken_lanes_reg :
                   t_empty ? fall_lanes_reg :
                   ((fall_lanes_reg | taken_lanes_reg) & ~stopped_reg);

        ftp_ok    = (ft_lanes == '0) || p_empty || (ft_pc == top_pc);
        ftp_pc    = (ft_lanes == '0) ? top_pc : ft_pc;
        ftp_lanes = (ft_lanes == '0) ? top_lanes :
                    p_empty ? ft_lanes : ((ft_lanes | top_lanes) & ~stopped_reg);

        // only used when both groups hold lanes
        fp_ok    = p_empty || (fall_pc_reg == top_pc);
        fp_lanes = p_empty ? fall_lanes_reg : ((fall_lanes_reg | top_lanes) & ~stopped_reg);
        tp_ok    = p_empty || (taken_pc_reg == top_pc);
        tp_lanes = p_empty ? taken_lanes_reg : ((taken_lanes_reg | top_lanes) & ~stopped_reg);

        push_a_val = {top_pc, top_lanes};
        push_b_val = {taken_pc_reg, taken_lanes_reg};
        if (ft_ok)
        begin
            if (ftp_ok)
            begin
                res_pc    = ftp_pc;
                res_lanes = ftp_lanes;
                push_n    = 2'd0;
            end
            else
            begin
                res_pc    = ft_pc;
                res_lanes = ft_lanes;
                push_n    = 2'd1;
            end
        end
        else if (fp_ok)
        begin
            res_pc     = fall_pc_reg;
            res_lanes  = fp_lanes;
            push_a_val = {taken_pc_reg, taken_lanes_reg};
            push_n     = 2'd1;
        end
        else if (tp_ok)
        begin
            res_pc     = taken_pc_reg;
            res_lanes  = tp_lanes;
            push_a_val = {fall_pc_reg, fall_lanes_reg};
            push_n     = 2'd1;
        end
        else
        begin
            res_pc    = fall_pc_reg;
            res_lanes = fall_lanes_reg;
            push_n    = 2'd2;
        end
    end

    // next state of the warp
    always_comb
    begin
        warp_pc_next   = warp_pc_reg;
        active_next    = active_reg;
        stopped_next   = stopped_reg;
        tvalid_next    = tvalid_reg;
        stk_cnt_next   = stk_cnt_reg;
        scan_idx_next  = scan_idx_reg;
        done_next      = done_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;

        if (cmd.accept)
        begin
            scan_idx_next = '0;
            done_next     = 1'b0;
            ovf_next      = 1'b0;
        end

        if (cmd.exec)
        begin
            case (op_reg)
                sds_pkg::OP_LAUNCH:
                begin
                    warp_pc_next = addr_reg;
                    active_next  = launch_en;
                    stopped_next = ~launch_en;
                end
                sds_pkg::OP_RECORD:
                begin
                    if (tidx_ok)
                    begin
                        tvalid_next[tidx_idx] = 1'b1;
                    end
                end
                sds_pkg::OP_SET_PC:
                begin
                    warp_pc_next = addr_reg;
                    active_next  = mask_reg;
                end
                sds_pkg::OP_STOP:
                begin
                    done_next = all_stopped || (pc_zero && stk_empty);
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.scan_issue)
        begin
            scan_idx_next = scan_idx_reg + SXW'(1);
        end

        if (cmd.pop_load)
        begin
            warp_pc_next = stk_rd_pc;
            active_next  = stk_rd_lanes;
            stk_cnt_next = stk_cnt_dec;
        end

        if (cmd.merge && !stk_empty)
        begin
            stk_cnt_next = stk_cnt_dec;
        end

        if (push)
        begin
            if (stk_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                stk_cnt_next = stk_cnt_reg + SCW'(1);
            end
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warp_pc_reg   <= '0;
            active_reg    <= '0;
            stopped_reg   <= '1;
            tvalid_reg    <= '0;
            stk_cnt_reg   <= '0;
            scan_idx_reg  <= '0;
            done_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            proc_en_reg   <= 1'b0;
            push_two_reg  <= 1'b0;
        end
        else
        begin
            warp_pc_reg   <= warp_pc_next;
            active_reg    <= active_next;
            stopped_reg   <= stopped_next;
            tvalid_reg    <= tvalid_next;
            stk_cnt_reg   <= stk_cnt_next;
            scan_idx_reg  <= scan_idx_next;
            done_reg      <= done_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            proc_en_reg   <= cmd.scan_issue;
            if (cmd.merge)
            begin
                push_two_reg <= (push_n == 2'd2);
            end
        end
    end

    // lane next pc memory, entries without a valid bit read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.exec && (op_reg == sds_pkg::OP_RECORD) && tidx_ok)
        begin
            tnpc_mem[tidx_idx] <= addr_reg;
        end
        if (cmd.scan_issue)
        begin
            tnpc_rd_reg <= tnpc_mem[scan_lane];
        end
    end

    // reconvergence stack
    always_ff @(posedge clk)
    begin
        if (push && !stk_full)
        begin
            stk_mem[stk_cnt_reg[SIW-1:0]] <= push_data;
        end
        if (cmd.stack_rd)
        begin
            stk_rd_reg <= stk_mem[stk_cnt_dec[SIW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg          <= opcode;
            tidx_reg        <= thread_index;
            addr_reg        <= address;
            mask_reg        <= lane_mask;
            tcount_reg      <= thread_count;
            fall_pc_reg     <= '0;
            taken_pc_reg    <= '0;
            fall_lanes_reg  <= '0;
            taken_lanes_reg <= '0;
        end
        else if (proc_en_reg && active_reg[proc_lane_reg])
        begin
            if (lane_pc != target_pc)
            begin
                taken_pc_reg                   <= lane_pc;
                taken_lanes_reg[proc_lane_reg] <= 1'b1;
            end
            else
            begin
                fall_pc_reg                   <= lane_pc;
                fall_lanes_reg[proc_lane_reg] <= 1'b1;
            end
        end

        if (cmd.scan_issue)
        begin
            proc_lane_reg  <= scan_lane;
            proc_valid_reg <= tvalid_reg[scan_lane];
        end

        if (cmd.merge)
        begin
            res_pc_reg    <= res_pc;
            res_lanes_reg <= res_lanes;
            push_a_reg    <= push_a_val;
            push_b_reg    <= push_b_val;
        end

        if (cmd.out_load)
        begin
            next_pc_reg    <= status.is_diverge ? res_pc_reg : warp_pc_reg;
            next_lanes_reg <= status.is_diverge ? res_lanes_reg : active_reg;
            warp_done_reg  <= done_reg;
            ovf_out_reg    <= ovf_reg;
        end
    end

    assign status.is_diverge = (op_reg == sds_pkg::OP_DIVERGE);
    assign status.pop_req    = (op_reg == sds_pkg::OP_STOP) && !all_stopped && pc_zero
                               && !stk_empty;
    assign status.scan_end   = (scan_idx_reg == SXW'(LANES));
    assign status.push_any   = (push_n != 2'd0);
    assign status.push_two   = push_two_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign next_pc        = next_pc_reg;
    assign next_lanes     = next_lanes_reg;
    assign warp_done      = warp_done_reg;
    assign stack_overflow = ovf_out_reg;

    `SDS_ASSERT_NEXT(a_pop_count, cmd.merge && !stk_empty, stk_cnt_reg == $past(stk_cnt_dec), "merge pop did not lower stack count")
    `SDS_ASSERT_NEXT(a_push_count, push && !stk_full, stk_cnt_reg == $past(stk_cnt_reg) + SCW'(1), "push did not raise stack count")
    `SDS_ASSERT_IMPL(a_groups_disjoint, cmd.merge, (fall_lanes_reg & taken_lanes_reg) == '0, "lane in both groups")
    `SDS_ASSERT_IMPL(a_groups_active, cmd.merge, ((fall_lanes_reg | taken_lanes_reg) & ~active_reg) == '0, "inactive lane in a group")
    `SDS_ASSERT_IMPL(a_ovf_cause, $rose(ovf_reg), $past(push) && $past(stk_full), "overflow without a push onto a full stack")

endmodule

@@ rtl/core/simt_divergence_stack_core.sv @@
// top level of the simt warp control core with reconvergence stack
// One warp of LANES threads shares a pc and an active lane mask. Items carry an opcode:
// launch (start pc, first thread_count lanes enabled, the rest stopped), record a thread's
// next pc, diverge (split active lanes into fall-through at pc+4 and taken, merge with the
// popped stack top, push what did not merge), set pc and lanes, and stop check (done when
// all lanes are stopped or pc is zero with an empty stack, else pop the stack when pc is
// zero). Every item returns exactly one result item. Items are handled one at a time. The
// length of a diverge is set by the scan of the lane next pc memory, whose single read
// port delivers one lane per cycle, and grows with each push onto the stack. A new item is
// taken while the previous result still waits in the output register. Lane next pcs read
// as zero until recorded; stack entries are only read below the stack count, so no
// clearing pass is needed after reset.
module simt_divergence_stack_core
#(
    parameter int LANES       = sds_pkg::LANES_DEF,
    parameter int STACK_DEPTH = sds_pkg::STACK_DEPTH_DEF,
    parameter int PC_BITS     = sds_pkg::PC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // item input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sds_pkg::OPCODE_W-1:0]  opcode,
    input  logic [sds_pkg::TIDX_W-1:0]    thread_index,
    input  logic [PC_BITS-1:0]            address,
    input  logic [LANES-1:0]              lane_mask,
    input  logic [sds_pkg::TCOUNT_W-1:0]  thread_count,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [PC_BITS-1:0]            next_pc,
    output logic [LANES-1:0]              next_lanes,
    output logic                          warp_done,
    output logic                          stack_overflow
);

    // commands from the sequencer, status back from the datapath
    sds_pkg::sds_cmd_t    cmd;
    sds_pkg::sds_status_t status;

    // sequencer: accept, execute, lane scan, merge, pushes, pop, result load
    sds_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // warp registers, lane pc memory, stack memory and output register
    sds_datapath
    #(
        .LANES       (LANES),
        .STACK_DEPTH (STACK_DEPTH),
        .PC_BITS     (PC_BITS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .opcode         (opcode),
        .thread_index   (thread_index),
        .address        (address),
        .lane_mask      (lane_mask),
        .thread_count   (thread_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_pc        (next_pc),
        .next_lanes     (next_lanes),
        .warp_done      (warp_done),
        .stack_overflow (stack_overflow)
    );

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the simt warp control core with reconvergence stack
`timescale 1ns / 1ps

module tb_top;
    import sds_pkg::*;

    localparam int LANES       = LANES_DEF;
    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int PC_BITS     = PC_BITS_DEF;

    // opcodes the core leaves unused
    localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int QUIET_LIMIT   = 20000;
    localparam int ITEMS_A_PHASE = 300;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [TIDX_W-1:0]   tidx;
        logic [PC_BITS-1:0]  addr;
        logic [LANES-1:0]    mask;
        logic [TCOUNT_W-1:0] count;
        logic                drain;
    } warp_op_t;

    typedef struct packed {
        logic [PC_BITS-1:0] pc;
        logic [LANES-1:0]   lanes;
        logic               done;
        logic               ovf;
    } warp_res_t;

    typedef struct packed {
        logic [PC_BITS-1:0] pc;
        logic [LANES-1:0]   lanes;
    } lane_grp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [TIDX_W-1:0]   thread_index = '0;
    logic [PC_BITS-1:0]  address = '0;
    logic [LANES-1:0]    lane_mask = '0;
    logic [TCOUNT_W-1:0] thread_count = '0;

    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [PC_BITS-1:0]  next_pc;
    logic [LANES-1:0]    next_lanes;
    logic                warp_done;
    logic                stack_overflow;

    simt_divergence_stack_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .thread_index   (thread_index),
        .address        (address),
        .lane_mask      (lane_mask),
        .thread_count   (thread_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_pc        (next_pc),
        .next_lanes     (next_lanes),
        .warp_done      (warp_done),
        .stack_overflow (stack_overflow)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // items waiting to be sent, results waiting to come back
    warp_op_t  op_queue [$];
    warp_res_t result_due_q [$];

    int   idle_pct = 0;
    int   stall_pct = 0;
    int   errors = 0;
    int   quiet_cycles = 0;
    int   planned = 0;
    logic in_taken = 1'b0;
    logic [PC_BITS-1:0] pc_pool [8];

    // ------------------------------------------------------------------
    // warp state as the core should hold it
    // ------------------------------------------------------------------
    logic [PC_BITS-1:0] m_pc = '0;
    logic [LANES-1:0]   m_active = '0;
    logic [LANES-1:0]   m_stopped = '1;
    logic [PC_BITS-1:0] m_thread_pc [LANES];
    lane_grp_t          m_stack [STACK_DEPTH];
    int                 m_depth = 0;
    logic               m_ovf = 1'b0;

    initial begin
        for (int i = 0; i < LANES; i++)
            m_thread_pc[i] = '0;
    end

    function automatic void push_grp(input lane_grp_t g);
        if (m_depth >= STACK_DEPTH)
            m_ovf = 1'b1;
        else
        begin
            m_stack[m_depth] = g;
            m_depth++;
        end
    endfunction

    // m gets a merged into b, or a unchanged when the pcs differ
    function automatic bit merge_grp(input lane_grp_t a, input lane_grp_t b,
                                     output lane_grp_t m);
        m = a;
        if (a.lanes == '0)
        begin
            m = b;
            return 1'b1;
        end
        if (b.lanes == '0)
            return 1'b1;
        if (a.pc == b.pc)
        begin
            m.lanes = (a.lanes | b.lanes) & ~m_stopped;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic lane_grp_t resolve_branch();
        lane_grp_t fall, taken, top, joined, res;
        logic [PC_BITS-1:0] target;
        fall   = '0;
        taken  = '0;
        top    = '0;
        target = m_pc + PC_BITS'(PC_STEP);
        for (int i = 0; i < LANES; i++)
        begin
            if (m_active[i])
            begin
                if (m_thread_pc[i] != target)
                begin
                    taken.pc       = m_thread_pc[i];
                    taken.lanes[i] = 1'b1;
                end
                else
                begin
                    fall.pc       = m_thread_pc[i];
                    fall.lanes[i] = 1'b1;
                end
            end
        end
        if (m_depth > 0)
        begin
            m_depth--;
            top = m_stack[m_depth];
        end
        if (merge_grp(fall, taken, joined))
        begin
            if (!merge_grp(joined, top, res))
                push_grp(top);
        end
        else if (merge_grp(fall, top, res))
            push_grp(taken);
        else if (merge_grp(taken, top, res))
            push_grp(fall);
        else
        begin
            push_grp(top);
            push_grp(taken);
            res = fall;
        end
        return res;
    endfunction

    function automatic warp_res_t step_warp(input warp_op_t it);
        warp_res_t r;
        lane_grp_t g;
        r     = '0;
        m_ovf = 1'b0;
        case (it.op)
            OP_LAUNCH:
            begin
                if (it.count >= LANES)
                    m_active = '1;
                else
                    m_active = (LANES'(1) << it.count) - LANES'(1);
                m_stopped = ~m_active;
                m_pc      = it.addr;
            end
            OP_RECORD:
            begin
                if (it.tidx < LANES)
                    m_thread_pc[it.tidx] = it.addr;
            end
            OP_SET_PC:
            begin
                m_pc     = it.addr;
                m_active = it.mask;
            end
            OP_STOP:
            begin
                if (&m_stopped)
                    r.done = 1'b1;
                else if (m_pc == '0)
                begin
                    if (m_depth == 0)
                        r.done = 1'b1;
                    else
                    begin
                        m_depth--;
                        m_pc     = m_stack[m_depth].pc;
                        m_active = m_stack[m_depth].lanes;
                    end
                end
            end
            default: ;
        endcase
        if (it.op == OP_DIVERGE)
        begin
            g       = resolve_branch();
            r.pc    = g.pc;
            r.lanes = g.lanes;
        end
        else
        begin
            r.pc    = m_pc;
            r.lanes = m_active;
        end
        r.ovf = m_ovf;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_op(input logic [OPCODE_W-1:0] op, input logic [TIDX_W-1:0] tidx,
                          input logic [PC_BITS-1:0] addr, input logic [LANES-1:0] mask,
                          input logic [TCOUNT_W-1:0] count, input bit drain);
        warp_op_t it;
        it.op    = op;
        it.tidx  = tidx;
        it.addr  = addr;
        it.mask  = mask;
        it.count = count;
        it.drain = drain;
        op_queue.push_back(it);
        planned++;
    endtask

    function automatic logic [PC_BITS-1:0] rand_addr();
        return PC_BITS'({$urandom, $urandom});
    endfunction

    // next pcs cluster around the fall-through target so groups merge often
    function automatic logic [PC_BITS-1:0] pick_target(input logic [PC_BITS-1:0] base);
        case ($urandom_range(0, 3))
            0, 1:    return base + PC_BITS'(PC_STEP);
            2:       return base + PC_BITS'(PC_STEP * $urandom_range(2, 5));
            default: return pc_pool[$urandom_range(0, 7)];
        endcase
    endfunction

    // launch, then a random mix of records, branches, pc updates and stop checks
    task automatic gen_warp_run(input bit drain);
        logic [PC_BITS-1:0] base;
        int                 cnt;
        base = pc_pool[$urandom_range(0, 7)];
        cnt  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, LANES);
        add_op(OP_LAUNCH, TIDX_W'($urandom), base, LANES'($urandom), TCOUNT_W'(cnt), drain);
        repeat ($urandom_range(3, 14))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    add_op(OP_RECORD, TIDX_W'($urandom), pick_target(base), LANES'($urandom),
                           TCOUNT_W'($urandom), 1'b0);
                4, 5, 6:
                    add_op(OP_DIVERGE, TIDX_W'($urandom), rand_addr(), LANES'($urandom),
                           TCOUNT_W'($urandom), 1'b0);
                7:
                    add_op(OP_SET_PC, TIDX_W'($urandom),
                           $urandom_range(0, 1) ? '0 : pick_target(base),
                           LANES'($urandom), TCOUNT_W'($urandom), 1'b0);
                default:
                    add_op(OP_STOP, TIDX_W'($urandom), rand_addr(), LANES'($urandom),
                           TCOUNT_W'($urandom), 1'b0);
            endcase
        end
    endtask

    // each branch gets a fresh taken pc on the top lane, so the stack grows
    // by one per branch and runs into overflow on the longer climbs
    task automatic gen_stack_climb(input bit drain);
        logic [PC_BITS-1:0] base;
        int                 cnt;
        base = pc_pool[$urandom_range(0, 7)];
        cnt  = $urandom_range(2, LANES);
        add_op(OP_LAUNCH, '0, base, '0, TCOUNT_W'(cnt), drain);
        add_op(OP_RECORD, '0, base + PC_BITS'(PC_STEP), '0, '0, 1'b0);
        repeat ($urandom_range(6, 20))
        begin
            add_op(OP_RECORD, TIDX_W'(cnt - 1), rand_addr(), '0, '0, 1'b0);
            add_op(OP_DIVERGE, TIDX_W'($urandom), rand_addr(), LANES'($urandom),
                   TCOUNT_W'($urandom), 1'b0);
        end
        // unwind part of the stack through stop checks at pc zero
        repeat ($urandom_range(1, 5))
        begin
            add_op(OP_SET_PC, '0, '0, LANES'($urandom), '0, 1'b0);
            add_op(OP_STOP, '0, '0, '0, '0, 1'b0);
        end
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 4))
            add_op(OPCODE_W'($urandom_range(OP_LAUNCH, OP_SPARE_7)), TIDX_W'($urandom),
                   rand_addr(), LANES'($urandom), TCOUNT_W'($urandom), 1'b0);
    endtask

    task automatic gen_directed();
        logic [PC_BITS-1:0] top_pc;
        top_pc = '1;
        add_op(OP_STOP,    '0,  '0, '0, '0, 1'b0);        // all lanes stopped after reset
        add_op(OP_DIVERGE, '0,  '0, '0, '0, 1'b0);        // no active lanes, empty stack
        add_op(OP_LAUNCH,  '0,  '0, '0, '0, 1'b0);        // zero threads
        add_op(OP_STOP,    '0,  '0, '0, '0, 1'b0);
        // pc + 4 wraps to zero at the top of the address space
        add_op(OP_LAUNCH,  '1,  top_pc - PC_BITS'(3), '1, TCOUNT_W'(LANES + 1), 1'b0);
        add_op(OP_RECORD,  '0,  '0, '1, '1, 1'b0);
        add_op(OP_RECORD,  '1,  top_pc, '0, '0, 1'b0);
        add_op(OP_DIVERGE, '0,  '0, '0, '0, 1'b0);
        add_op(OP_LAUNCH,  '0,  PC_BITS'(32'h1000), '0, TCOUNT_W'(LANES), 1'b0);
        add_op(OP_RECORD,  TIDX_W'(5), PC_BITS'(32'h2000), '0, '0, 1'b0);
        add_op(OP_DIVERGE, '0,  '0, '0, '0, 1'b0);
        add_op(OP_SET_PC,  '0,  '0, '0, '0, 1'b0);
        add_op(OP_STOP,    '0,  '0, '0, '0, 1'b0);        // pc zero, stack empty after the merge
        add_op(OP_STOP,    '0,  '0, '0, '0, 1'b0);        // pc still zero, stack still empty
        add_op(OP_SET_PC,  '0,  '0, '1, '0, 1'b0);
        add_op(OP_STOP,    '0,  '0, '0, '0, 1'b0);        // pc zero, stack empty
        add_op(OP_LAUNCH,  '0,  rand_addr(), '0, '1, 1'b0);
        add_op(OP_SPARE_5, '1,  top_pc, '1, '1, 1'b0);
        add_op(OP_SPARE_7, '0,  '0, '0, '0, 1'b0);
        add_op(OP_SET_PC,  '1,  top_pc, '1, '1, 1'b0);
        add_op(OP_RECORD,  '1,  '0, '0, '0, 1'b0);
        add_op(OP_LAUNCH,  '0,  PC_BITS'(32'h40), '0, TCOUNT_W'(1), 1'b0);
        add_op(OP_DIVERGE, '0,  '0, '0, '0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // sequencing of the run
    // ------------------------------------------------------------------
    initial begin
        int idle_tbl  [4];
        int stall_tbl [4];
        bit first;
        idle_tbl  = '{0, 50, 0, 37};
        stall_tbl = '{0, 0, 50, 37};
        for (int i = 0; i < 8; i++)
            pc_pool[i] = rand_addr() & ~PC_BITS'(3);
        pc_pool[0] = PC_BITS'(32'h100);
        pc_pool[1] = ~PC_BITS'(3);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_tbl[p];
            stall_pct = stall_tbl[p];
            if (p == 0)
                gen_directed();
            planned = 0;
            first   = 1'b1;
            while (planned < ITEMS_A_PHASE)
            begin
                // now and then hold the next item back until the core has drained
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: gen_warp_run(first || $urandom_range(0, 7) == 0);
                    5, 6:          gen_stack_climb(first || $urandom_range(0, 7) == 0);
                    default:       gen_noise();
                endcase
                first = 1'b0;
            end
            while (op_queue.size() != 0 || in_valid || result_due_q.size() != 0)
                @(posedge clk);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: new item or idle at the falling edge, payload held while waiting
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        warp_op_t it;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (op_queue.size() != 0 && !(op_queue[0].drain && result_due_q.size() != 0)
                && $urandom_range(0, 99) >= idle_pct)
            begin
                it = op_queue.pop_front();
                in_valid     <= 1'b1;
                opcode       <= it.op;
                thread_index <= it.tidx;
                address      <= it.addr;
                lane_mask    <= it.mask;
                thread_count <= it.count;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: results checked and items predicted at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        warp_res_t   exp_r;
        warp_op_t    cur;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;

            if (out_valid && out_ready)
            begin
                if (result_due_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got pc %h lanes %h",
                             $time, next_pc, next_lanes);
                    errors++;
                end
                else
                begin
                    exp_r = result_due_q.pop_front();
                    check_field("next_pc", 64'(exp_r.pc), 64'(next_pc));
                    check_field("next_lanes", 64'(exp_r.lanes), 64'(next_lanes));
                    check_field("warp_done", 64'(exp_r.done), 64'(warp_done));
                    check_field("stack_overflow", 64'(exp_r.ovf), 64'(stack_overflow));
                end
            end

            if (in_valid && in_ready)
            begin
                cur.op    = opcode;
                cur.tidx  = thread_index;
                cur.addr  = address;
                cur.mask  = lane_mask;
                cur.count = thread_count;
                cur.drain = 1'b0;
                result_due_q.push_back(step_warp(cur));
            end

            // watchdog on cycles with no item moving on either side
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("%0t: timeout, no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
